// File: rtl/wti_pkg.sv
// Shared types, constants and codes of the interpolating wavetable reader.
package wti_pkg;

  localparam int DEPTH_DEF    = 65536;
  localparam int CHANNELS_DEF = 2;

  localparam int SW  = 24;      // sample width
  localparam int FW  = 24;      // fraction width
  localparam int LW  = 17;      // table length and index width
  localparam int HW  = 28;      // Hermite basis width
  localparam int TBW = 34;      // tension times bias width
  localparam int MW  = 35;      // multiplier operand width
  localparam int PAW = 5;       // APB address width

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [2:0] {
    MODE_LINEAR   = 3'd0,
    MODE_CUBIC    = 3'd1,
    MODE_SPLINE   = 3'd2,
    MODE_HERMITE  = 3'd3,
    MODE_LAGRANGE = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_BIAS    = 3'd1,
    REG_TENSION = 3'd2,
    REG_LENGTH  = 3'd3,
    REG_READY   = 3'd4,
    REG_MASK    = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_INDEX,
    ST_WRAP,
    ST_CUBE,
    ST_HERM,
    ST_CHAN,
    ST_READ,
    ST_LAST,
    ST_CALC,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic               operation;
    logic [5:0]         chan_sel;
    logic [15:0]        entry_addr;
    logic signed [23:0] entry_value;
    logic signed [31:0] phase;
  } item_t;

  typedef struct packed {
    logic [5:0]         out_chan;
    logic signed [23:0] out_value;
    logic               last_chan;
  } result_t;

  // Per-read interpolation setup handed to the arithmetic unit.
  typedef struct packed {
    mode_t                 mode;
    logic [FW-1:0]         f;
    logic signed [HW-1:0]  h0;
    logic signed [HW-1:0]  h1;
    logic signed [HW-1:0]  h2;
    logic signed [HW-1:0]  h3;
    logic signed [TBW-1:0] tbp;
    logic signed [TBW-1:0] tbm;
  } coef_t;

endpackage

// File: rtl/wti_ram.sv
// Generic memory with one write port and one registered read port.
module wti_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/wti_calc.sv
// Sequenced arithmetic unit: one multiply step and one add step in turn per sample.
module wti_calc (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  wti_pkg::coef_t        coef,
  input  logic signed [23:0]    a,
  input  logic signed [23:0]    b,
  input  logic signed [23:0]    c,
  input  logic signed [23:0]    d,
  output logic                  done,
  output logic signed [23:0]    value
);

  localparam int MW  = wti_pkg::MW;
  localparam int PRW = 2 * MW;

  localparam logic signed [PRW-1:0] H23    = 1 << 23;
  localparam logic signed [PRW-1:0] H24    = 1 << 24;
  localparam logic signed [PRW-1:0] H28    = 1 << 28;
  localparam logic signed [PRW-1:0] THREE  = 3 << 24;
  localparam logic signed [PRW-1:0] FIVE   = 5;
  localparam logic signed [PRW-1:0] SMAXW  = 8388607;
  localparam logic signed [PRW-1:0] SMINW  = -8388608;
  localparam logic signed [MW-1:0]  RECIP6 = 35'sh0AAAAAAAB;
  localparam logic signed [MW-1:0]  ONE24  = 1 << 24;

  logic                  busy;
  logic [3:0]            step;
  logic [2:0]            k;
  logic signed [MW-1:0]  ea, eb, ec, ed, ef, onemf;
  logic signed [MW-1:0]  cmb, q0c, q1c, q2, q0s, q1s, lq;
  logic signed [MW-1:0]  opa, opb;
  logic signed [PRW-1:0] prod_w, prod;
  logic signed [MW-1:0]  t, t_next, m0, m0_next, m1, m1_next;
  logic signed [PRW-1:0] acc, acc_next;
  logic                  ysgn, ysgn_next;
  logic signed [PRW-1:0] r24, r25, sum, r29, yv, uv, qv, fin_w;
  logic                  last_step;

  assign k = step[3:1];

  assign ea    = MW'(a);
  assign eb    = MW'(b);
  assign ec    = MW'(c);
  assign ed    = MW'(d);
  assign ef    = MW'($signed({1'b0, coef.f}));
  assign onemf = ONE24 - ef;
  assign cmb   = ec - eb;
  assign q0c   = ed - ea + eb - ec;
  assign q1c   = ea - eb - q0c;
  assign q2    = ec - ea;
  assign q0s   = (ed - ea) + 3 * (eb - ec);
  assign q1s   = 2 * (ea - eb) + q2 - q0s;
  assign lq    = (ed - ea) - 3 * cmb;

  always_comb begin
    opa = '0;
    opb = '0;
    case (coef.mode)
      wti_pkg::MODE_LINEAR: begin
        opa = cmb;
        opb = ef;
      end
      wti_pkg::MODE_CUBIC: begin
        opa = (k == 3'd0) ? q0c : t;
        opb = ef;
      end
      wti_pkg::MODE_SPLINE: begin
        opa = (k == 3'd0) ? q0s : t;
        opb = ef;
      end
      wti_pkg::MODE_HERMITE: begin
        unique case (k)
          3'd0: begin opa = eb - ea;          opb = MW'(coef.tbp); end
          3'd1: begin opa = cmb;              opb = MW'(coef.tbm); end
          3'd2: begin opa = cmb;              opb = MW'(coef.tbp); end
          3'd3: begin opa = ed - ec;          opb = MW'(coef.tbm); end
          3'd4: begin opa = MW'(coef.h0);     opb = eb;            end
          3'd5: begin opa = MW'(coef.h1);     opb = m0;            end
          3'd6: begin opa = MW'(coef.h2);     opb = m1;            end
          3'd7: begin opa = MW'(coef.h3);     opb = ec;            end
        endcase
      end
      default: begin
        case (k)
          3'd0:    begin opa = lq; opb = ef;     end
          3'd1:    begin opa = t;  opb = onemf;  end
          3'd2:    begin opa = t;  opb = RECIP6; end
          default: begin opa = t;  opb = ef;     end
        endcase
      end
    endcase
  end

  assign prod_w = opa * opb;

  // Rounded views of the registered product.
  assign r24 = (prod + H23) >>> 24;
  assign r25 = (prod + H24) >>> 25;
  assign sum = acc + prod;
  assign r29 = (sum + H28) >>> 29;
  assign yv  = (prod + THREE) >>> 24;
  assign uv  = yv[PRW-1] ? (FIVE - yv) : yv;
  assign qv  = prod >>> 34;

  always_comb begin
    t_next    = t;
    m0_next   = m0;
    m1_next   = m1;
    acc_next  = acc;
    ysgn_next = ysgn;
    fin_w     = '0;
    last_step = 1'b0;
    case (coef.mode)
      wti_pkg::MODE_LINEAR: begin
        fin_w     = PRW'(eb) + r24;
        last_step = 1'b1;
      end
      wti_pkg::MODE_CUBIC, wti_pkg::MODE_SPLINE: begin
        case (k)
          3'd0: begin
            t_next = (coef.mode == wti_pkg::MODE_CUBIC) ? MW'(PRW'(q1c) + r24)
                                                        : MW'(PRW'(q1s) + r24);
          end
          3'd1: t_next = MW'(PRW'(q2) + r24);
          default: begin
            fin_w     = (coef.mode == wti_pkg::MODE_CUBIC) ? PRW'(eb) + r24
                                                           : PRW'(eb) + r25;
            last_step = 1'b1;
          end
        endcase
      end
      wti_pkg::MODE_HERMITE: begin
        unique case (k)
          3'd0, 3'd2, 3'd4: acc_next = prod;
          3'd1:             m0_next  = MW'(r29);
          3'd3:             m1_next  = MW'(r29);
          3'd5, 3'd6:       acc_next = sum;
          3'd7: begin
            fin_w     = (sum + H23) >>> 24;
            last_step = 1'b1;
          end
        endcase
      end
      default: begin
        case (k)
          3'd0: t_next = MW'(r24 + PRW'(ed) + 2 * PRW'(ea) - 3 * PRW'(eb));
          3'd1: begin
            ysgn_next = yv[PRW-1];
            t_next    = MW'(uv);
          end
          3'd2: t_next = ysgn ? MW'(PRW'(cmb) + qv) : MW'(PRW'(cmb) - qv);
          default: begin
            fin_w     = PRW'(eb) + r24;
            last_step = 1'b1;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= prod_w;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 4'd1;
        if (step[0]) begin
          t    <= t_next;
          m0   <= m0_next;
          m1   <= m1_next;
          acc  <= acc_next;
          ysgn <= ysgn_next;
          if (last_step) begin
            busy <= 1'b0;
            done <= 1'b1;
            if (fin_w > SMAXW) begin
              value <= 24'sh7FFFFF;
            end else if (fin_w < SMINW) begin
              value <= -24'sh800000;
            end else begin
              value <= fin_w[23:0];
            end
          end
        end
      end
    end
  end

endmodule

// File: rtl/wavetable_interp_reader.sv
// Top level of the multichannel interpolating wavetable reader.
// The block holds one circular table of signed Q1.23 samples per channel in a
// single synchronous memory. A write beat (operation 0) stores one sample;
// it is dropped when the channel or address lies outside the table. A read
// beat (operation 1) carries a Q8.24 phase; a phase below 0 or above 1.0
// reads as 0. The phase is scaled by the table length and the four
// neighbouring points wrap around the table. Each channel then returns one
// result beat, channel 0 first, with last_chan set on the final channel. The
// interpolation (linear, cubic, Catmull spline, Hermite or Lagrange) comes
// from interp_mode; codes 5 to 7 act as Lagrange. A channel whose bit in
// present_mask is clear, or any channel while table_ready is 0, returns 0.
// Steps of a read: after the beat is taken, the setup states SCALE, INDEX,
// WRAP, CUBE and HERM (phase scaling and the shared Hermite basis), then for
// each present channel a state to select the channel, four memory reads over
// the single read port, a state to land the last sample, the arithmetic
// unit's sequence of alternating multiply and add steps, its done flag, and
// a state to hand the beat to the output register, which waits while that
// register is still full. An absent channel goes from channel select straight
// to the output hand-off. The output register frees the input side: a new
// beat is taken while the last result still waits.
// Configuration goes through the APB port and must only change while the
// block is idle. Samples never written read back as unknown data.
module wavetable_interp_reader #(
  parameter int DEPTH    = wti_pkg::DEPTH_DEF,
  parameter int CHANNELS = wti_pkg::CHANNELS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  wti_pkg::item_t          item,
  output logic                    result_valid,
  input  logic                    result_ready,
  output wti_pkg::result_t        result,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [wti_pkg::PAW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int LW  = wti_pkg::LW;
  localparam int FW  = wti_pkg::FW;
  localparam int HW  = wti_pkg::HW;
  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RAW = $clog2(CHANNELS) + AW;

  localparam logic signed [16:0] QONE = 17'sd16384;

  wti_pkg::state_t state, state_next;

  // Configuration registers.
  logic [2:0]         interp_mode;
  logic signed [15:0] hermite_bias;
  logic signed [15:0] hermite_tension;
  logic [16:0]        table_length;
  logic               table_ready;
  logic [1:0]         present_mask;
  logic               cfg_write;
  wti_pkg::reg_idx_t  cfg_idx;

  // Per-read setup.
  logic [LW-1:0]      len, len_eff;
  logic [24:0]        pc, pc_eff;
  logic [41:0]        xpos;
  logic [LW-1:0]      idx [4];
  logic [LW:0]        ndx_raw;
  logic [LW-1:0]      ndx, im1, ip1;
  logic [24:0]        f2, f3;
  logic signed [HW-1:0] sf, sf2, sf3, hh2;
  logic signed [16:0] bplus, bminus, tmul;
  wti_pkg::coef_t     coef;
  wti_pkg::mode_t     mode_eff;

  // Channel loop.
  logic [CW-1:0]      ch;
  logic [1:0]         rd_cnt;
  logic signed [23:0] smp [4];
  logic signed [23:0] chan_value;
  logic               present;
  logic               out_free;

  // Memory ports.
  logic               ram_we;
  logic [RAW-1:0]     ram_waddr, ram_raddr;
  logic [23:0]        ram_rdata;

  // Arithmetic unit.
  logic               calc_start, calc_done;
  logic signed [23:0] calc_value;

  // Output register.
  logic               res_valid;
  wti_pkg::result_t   res;

  // ---------------------------------------------------------------- APB port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_idx   = wti_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode     <= 3'd4;
      hermite_bias    <= '0;
      hermite_tension <= '0;
      table_length    <= 17'd4;
      table_ready     <= 1'b0;
      present_mask    <= 2'b11;
    end else if (cfg_write) begin
      case (cfg_idx)
        wti_pkg::REG_MODE:    interp_mode     <= pwdata[2:0];
        wti_pkg::REG_BIAS:    hermite_bias    <= pwdata[15:0];
        wti_pkg::REG_TENSION: hermite_tension <= pwdata[15:0];
        wti_pkg::REG_LENGTH:  table_length    <= pwdata[16:0];
        wti_pkg::REG_READY:   table_ready     <= pwdata[0];
        wti_pkg::REG_MASK:    present_mask    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      wti_pkg::REG_MODE:    prdata = {29'd0, interp_mode};
      wti_pkg::REG_BIAS:    prdata = 32'(hermite_bias);
      wti_pkg::REG_TENSION: prdata = 32'(hermite_tension);
      wti_pkg::REG_LENGTH:  prdata = {15'd0, table_length};
      wti_pkg::REG_READY:   prdata = {31'd0, table_ready};
      wti_pkg::REG_MASK:    prdata = {30'd0, present_mask};
      default:              prdata = '0;
    endcase
  end

  // ------------------------------------------------------- read setup logic
  // Length clamped to 1..DEPTH; out-of-range phase forced to zero.
  always_comb begin
    if (table_length == '0) begin
      len_eff = LW'(1);
    end else if (32'(table_length) > DEPTH) begin
      len_eff = LW'(DEPTH);
    end else begin
      len_eff = table_length;
    end
    if (item.phase < 0 || item.phase > 32'sd16777216) begin
      pc_eff = '0;
    end else begin
      pc_eff = item.phase[24:0];
    end
    mode_eff = (interp_mode > 3'd4) ? wti_pkg::MODE_LAGRANGE
                                     : wti_pkg::mode_t'(interp_mode);
  end

  // Integer index and its wrapped neighbours. A phase of exactly 1.0 wraps to 0.
  assign ndx_raw = xpos[41:24];
  assign ndx     = (ndx_raw >= {1'b0, len}) ? '0 : ndx_raw[LW-1:0];
  assign im1     = (ndx == '0) ? len - LW'(1) : ndx - LW'(1);
  assign ip1     = ({1'b0, ndx} + 1'b1 == {1'b0, len}) ? '0 : ndx + LW'(1);

  assign bplus  = QONE + 17'(hermite_bias);
  assign bminus = QONE - 17'(hermite_bias);
  assign tmul   = QONE - 17'(hermite_tension);

  assign sf  = HW'($signed({1'b0, coef.f}));
  assign sf2 = HW'($signed({1'b0, f2}));
  assign sf3 = HW'($signed({1'b0, f3}));
  assign hh2 = sf3 - sf2;

  assign present = (32'(ch) >= 2) || present_mask[ch[0]];
  assign out_free = !res_valid || result_ready;

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wti_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    calc_start = 1'b0;
    unique case (state)
      wti_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid && item.operation == wti_pkg::OP_READ) begin
          state_next = wti_pkg::ST_SCALE;
        end
      end
      wti_pkg::ST_SCALE: state_next = wti_pkg::ST_INDEX;
      wti_pkg::ST_INDEX: state_next = wti_pkg::ST_WRAP;
      wti_pkg::ST_WRAP:  state_next = wti_pkg::ST_CUBE;
      wti_pkg::ST_CUBE:  state_next = wti_pkg::ST_HERM;
      wti_pkg::ST_HERM:  state_next = wti_pkg::ST_CHAN;
      wti_pkg::ST_CHAN: begin
        state_next = (table_ready && present) ? wti_pkg::ST_READ : wti_pkg::ST_PUT;
      end
      wti_pkg::ST_READ: begin
        if (rd_cnt == 2'd3) begin
          state_next = wti_pkg::ST_LAST;
        end
      end
      wti_pkg::ST_LAST: begin
        calc_start = 1'b1;
        state_next = wti_pkg::ST_CALC;
      end
      wti_pkg::ST_CALC: begin
        if (calc_done) begin
          state_next = wti_pkg::ST_PUT;
        end
      end
      wti_pkg::ST_PUT: begin
        if (out_free) begin
          state_next = (32'(ch) == CHANNELS - 1) ? wti_pkg::ST_IDLE : wti_pkg::ST_CHAN;
        end
      end
    endcase
  end

  // Datapath registers, loaded by state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ch     <= '0;
      rd_cnt <= '0;
    end else begin
      unique case (state)
        wti_pkg::ST_IDLE: begin
          len       <= len_eff;
          pc        <= pc_eff;
          coef.mode <= mode_eff;
          ch        <= '0;
        end
        wti_pkg::ST_SCALE: begin
          xpos     <= 42'(pc * len);
          coef.tbp <= wti_pkg::TBW'(tmul * bplus);
        end
        wti_pkg::ST_INDEX: begin
          coef.f   <= xpos[FW-1:0];
          idx[0]   <= im1;
          idx[1]   <= ndx;
          idx[2]   <= ip1;
          coef.tbm <= wti_pkg::TBW'(tmul * bminus);
        end
        wti_pkg::ST_WRAP: begin
          idx[3] <= ({1'b0, idx[2]} + 1'b1 == {1'b0, len}) ? '0 : idx[2] + LW'(1);
          f2     <= 25'((48'(coef.f) * 48'(coef.f) + 48'(1 << 23)) >> 24);
        end
        wti_pkg::ST_CUBE: begin
          f3 <= 25'((49'(coef.f) * 49'(f2) + 49'(1 << 23)) >> 24);
        end
        wti_pkg::ST_HERM: begin
          coef.h0 <= 2 * hh2 - sf2 + HW'(1 << 24);
          coef.h1 <= hh2 - sf2 + sf;
          coef.h2 <= hh2;
          coef.h3 <= sf2 - 2 * hh2;
        end
        wti_pkg::ST_CHAN: begin
          chan_value <= '0;
          rd_cnt     <= '0;
        end
        wti_pkg::ST_READ: begin
          if (rd_cnt != 2'd0) begin
            smp[rd_cnt - 2'd1] <= ram_rdata;
          end
          rd_cnt <= rd_cnt + 2'd1;
        end
        wti_pkg::ST_LAST: begin
          smp[3] <= ram_rdata;
        end
        wti_pkg::ST_CALC: begin
          if (calc_done) begin
            chan_value <= calc_value;
          end
        end
        wti_pkg::ST_PUT: begin
          if (out_free) begin
            ch <= ch + CW'(1);
          end
        end
      endcase
    end
  end

  // -------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == wti_pkg::ST_PUT && out_free) begin
      res_valid <= 1'b1;
    end else if (result_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == wti_pkg::ST_PUT && out_free) begin
      res.out_chan  <= 6'(ch);
      res.out_value <= chan_value;
      res.last_chan <= (32'(ch) == CHANNELS - 1);
    end
  end

  assign result_valid = res_valid;
  assign result       = res;

  // ----------------------------------------------------------- table memory
  // Channel number forms the upper address bits above the table index.
  assign ram_we = (state == wti_pkg::ST_IDLE) && item_valid &&
                  item.operation == wti_pkg::OP_WRITE &&
                  32'(item.chan_sel) < CHANNELS && 32'(item.entry_addr) < DEPTH;
  assign ram_waddr = RAW'({item.chan_sel[CW-1:0], AW'(item.entry_addr)});
  assign ram_raddr = RAW'({ch, AW'(idx[rd_cnt])});

  wti_ram #(
    .WIDTH (24),
    .DEPTH (CHANNELS << AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item.entry_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------- arithmetic unit
  wti_calc u_calc (
    .clk   (clk),
    .rst   (rst),
    .start (calc_start),
    .coef  (coef),
    .a     (smp[0]),
    .b     (smp[1]),
    .c     (smp[2]),
    .d     (smp[3]),
    .done  (calc_done),
    .value (calc_value)
  );

endmodule
